[hdl/spn16_ctr_cipher_top_assert.svh]
// ----------------------------------------------------------------------------
// spn16 assertion macros
// concurrent assertion shorthands clocked on clk, qualified by rst_n
// ----------------------------------------------------------------------------
`ifndef SPN16_CTR_CIPHER_TOP_ASSERT_SVH
`define SPN16_CTR_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define SPN16_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spn16 assertion failed");

// next-cycle implication, ignored while in reset
`define SPN16_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spn16 assertion failed");

// state following a reset cycle
`define SPN16_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("spn16 reset assertion failed");

`endif

[hdl/spn16_pkg.sv]
// ----------------------------------------------------------------------------
// spn16_pkg
// shared types, constants and helper functions of the spn16 ctr cipher
// ----------------------------------------------------------------------------
package spn16_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0]  KS_RCON_1  = 8'h80;
  localparam logic [7:0]  KS_RCON_2  = 8'h30;
  localparam logic [23:0] PERM_RESET = 24'hFAC688;

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [1:0] {
    REG_KEY      = 2'd0,
    REG_CTR_HIGH = 2'd1,
    REG_PERM     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] cipher_key;
    logic [7:0]  counter_high;
    logic [23:0] bit_permutation;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic        start_message;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [15:0] data_block;
  } item_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr_a;
    logic [7:0] raddr_b;
  } sbox_req_t;

  function automatic logic [7:0] nib_swap(input logic [7:0] b);
    return {b[3:0], b[7:4]};
  endfunction

  function automatic logic [7:0] perm_byte(input logic [7:0] b, input logic [23:0] perm);
    logic [7:0] r;
    logic [2:0] sel;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      sel             = perm[3*i +: 3];
      r[3'(7 - i)]    = b[3'd7 - sel];
    end
    return r;
  endfunction

endpackage

[hdl/spn16_ram.sv]
// ----------------------------------------------------------------------------
// spn16_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module spn16_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[hdl/spn16_sbox.sv]
// ----------------------------------------------------------------------------
// spn16_sbox
// substitution table store; entries not yet written read as zero
// ----------------------------------------------------------------------------
module spn16_sbox (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spn16_pkg::sbox_req_t  req,
  output logic [7:0]            rd_a,
  output logic [7:0]            rd_b
);

  logic [255:0] vld_r;
  logic         va_r;
  logic         vb_r;
  logic [7:0]   ram_a;
  logic [7:0]   ram_b;

  spn16_ram #(
    .WIDTH (8),
    .DEPTH (256)
  ) u_ram (
    .clk     (clk),
    .we      (req.we),
    .waddr   (req.waddr),
    .wdata   (req.wdata),
    .re      (req.re),
    .raddr_a (req.raddr_a),
    .raddr_b (req.raddr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
    if (req.re) begin
      va_r <= vld_r[req.raddr_a];
      vb_r <= vld_r[req.raddr_b];
    end
  end

  assign rd_a = va_r ? ram_a : 8'h00;
  assign rd_b = vb_r ? ram_b : 8'h00;

endmodule

[hdl/spn16_regs.sv]
// ----------------------------------------------------------------------------
// spn16_regs
// apb configuration registers: key, counter high byte, bit permutation
// ----------------------------------------------------------------------------
module spn16_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spn16_pkg::PADDR_W-1:0]   paddr,
  input  logic [spn16_pkg::PDATA_W-1:0]   pwdata,
  output logic [spn16_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output spn16_pkg::cfg_t                 cfg
);

  spn16_pkg::cfg_t     cfg_r;
  spn16_pkg::cfg_t     cfg_nxt;
  spn16_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx    = spn16_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        spn16_pkg::REG_KEY:      cfg_nxt.cipher_key      = pwdata[15:0];
        spn16_pkg::REG_CTR_HIGH: cfg_nxt.counter_high    = pwdata[7:0];
        spn16_pkg::REG_PERM:     cfg_nxt.bit_permutation = pwdata[23:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      spn16_pkg::REG_KEY:      prdata = {16'h0000, cfg_r.cipher_key};
      spn16_pkg::REG_CTR_HIGH: prdata = {24'h000000, cfg_r.counter_high};
      spn16_pkg::REG_PERM:     prdata = {8'h00, cfg_r.bit_permutation};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cipher_key      <= 16'h0000;
      cfg_r.counter_high    <= 8'h00;
      cfg_r.bit_permutation <= spn16_pkg::PERM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/spn16_core.sv]
// ----------------------------------------------------------------------------
// spn16_core
// sequencer: s-box table writes, key schedule and round lookups, output beat
// ----------------------------------------------------------------------------
module spn16_core #(
  parameter int unsigned ROUND_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spn16_pkg::cfg_t       cfg,
  input  logic                  pend_valid,
  input  spn16_pkg::item_t      pend_item,
  output logic                  take,
  output spn16_pkg::sbox_req_t  sbox_req,
  input  logic [7:0]            sbox_rd_a,
  input  logic [7:0]            sbox_rd_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_result_block,
  output logic [15:0]           out_counter_used,
  output logic [15:0]           out_keystream
);

  localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KS_A,
    ST_KS_B,
    ST_ROUND,
    ST_FIN
  } state_t;

  state_t           state_r,     state_nxt;
  logic [7:0]       low_ctr_r,   low_ctr_nxt;
  logic [RND_W-1:0] rnd_r,       rnd_nxt;
  logic [1:0]       ski_r,       ski_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      ctr_r,       ctr_nxt;
  logic [15:0]      data_r,      data_nxt;
  logic [7:0]       w2_r,        w2_nxt;
  logic [7:0]       w3_r,        w3_nxt;
  logic [7:0]       w4_r,        w4_nxt;
  logic [7:0]       w5_r,        w5_nxt;
  logic [15:0]      out_res_r,   out_res_nxt;
  logic [15:0]      out_ctr_r,   out_ctr_nxt;
  logic [15:0]      out_ks_r,    out_ks_nxt;

  logic        out_free;
  logic [7:0]  perm_a;
  logic [7:0]  perm_b;
  logic [15:0] sk_sel;
  logic [15:0] m_cur;
  logic [15:0] m_x;
  logic [7:0]  ctr_low;
  logic [7:0]  w2_calc;
  logic [7:0]  w3_calc;
  logic [7:0]  w4_calc;
  logic [7:0]  w5_calc;

  assign out_free = !out_valid_r || !out_stall;
  assign take     = pend_valid &&
                    ((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));

  assign perm_a = spn16_pkg::perm_byte(sbox_rd_a, cfg.bit_permutation);
  assign perm_b = spn16_pkg::perm_byte(sbox_rd_b, cfg.bit_permutation);

  always_comb begin
    unique case (ski_r)
      2'd1:    sk_sel = {w2_r, w3_r};
      2'd2:    sk_sel = {w4_r, w5_r};
      default: sk_sel = cfg.cipher_key;
    endcase
  end

  assign m_cur   = (rnd_r == '0) ? ctr_r : {perm_a, perm_b};
  assign m_x     = m_cur ^ sk_sel;
  assign ctr_low = pend_item.start_message ? 8'h00 : low_ctr_r;
  assign w2_calc = cfg.cipher_key[15:8] ^ spn16_pkg::KS_RCON_1 ^ sbox_rd_a;
  assign w3_calc = w2_calc ^ cfg.cipher_key[7:0];
  assign w4_calc = w2_r ^ spn16_pkg::KS_RCON_2 ^ sbox_rd_a;
  assign w5_calc = w4_calc ^ w3_r;

  always_comb begin
    state_nxt     = state_r;
    low_ctr_nxt   = low_ctr_r;
    rnd_nxt       = rnd_r;
    ski_nxt       = ski_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctr_nxt       = ctr_r;
    data_nxt      = data_r;
    w2_nxt        = w2_r;
    w3_nxt        = w3_r;
    w4_nxt        = w4_r;
    w5_nxt        = w5_r;
    out_res_nxt   = out_res_r;
    out_ctr_nxt   = out_ctr_r;
    out_ks_nxt    = out_ks_r;

    sbox_req.we      = 1'b0;
    sbox_req.waddr   = pend_item.table_index;
    sbox_req.wdata   = pend_item.table_value;
    sbox_req.re      = 1'b0;
    sbox_req.raddr_a = m_x[15:8];
    sbox_req.raddr_b = m_x[7:0];

    unique case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      ST_KS_A: begin
        sbox_req.re      = 1'b1;
        sbox_req.raddr_a = spn16_pkg::nib_swap(cfg.cipher_key[7:0]);
        state_nxt        = ST_KS_B;
      end
      ST_KS_B: begin
        sbox_req.re      = 1'b1;
        sbox_req.raddr_a = spn16_pkg::nib_swap(w3_calc);
        w2_nxt           = w2_calc;
        w3_nxt           = w3_calc;
        state_nxt        = ST_ROUND;
      end
      ST_ROUND: begin
        sbox_req.re = 1'b1;
        if (rnd_r == '0) begin
          w4_nxt = w4_calc;
          w5_nxt = w5_calc;
        end
        rnd_nxt = rnd_r + 1'b1;
        ski_nxt = (ski_r == 2'd2) ? 2'd0 : ski_r + 2'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ks_nxt    = {perm_a, perm_b};
          out_res_nxt   = data_r ^ {perm_a, perm_b};
          out_ctr_nxt   = ctr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (take) begin
      if (pend_item.kind == spn16_pkg::KIND_TABLE) begin
        sbox_req.we = 1'b1;
      end else begin
        ctr_nxt     = {cfg.counter_high, ctr_low};
        low_ctr_nxt = ctr_low + 8'd1;
        data_nxt    = pend_item.data_block;
        rnd_nxt     = '0;
        ski_nxt     = 2'd0;
        state_nxt   = ST_KS_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctr_r     <= ctr_nxt;
    data_r    <= data_nxt;
    w2_r      <= w2_nxt;
    w3_r      <= w3_nxt;
    w4_r      <= w4_nxt;
    w5_r      <= w5_nxt;
    out_res_r <= out_res_nxt;
    out_ctr_r <= out_ctr_nxt;
    out_ks_r  <= out_ks_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_ctr_r   <= 8'h00;
      rnd_r       <= '0;
      ski_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_ctr_r   <= low_ctr_nxt;
      rnd_r       <= rnd_nxt;
      ski_r       <= ski_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_res_r;
  assign out_counter_used = out_ctr_r;
  assign out_keystream    = out_ks_r;

endmodule

[hdl/spn16_ctr_cipher_top.sv]
// ----------------------------------------------------------------------------
// spn16_ctr_cipher_top
// 16-bit spn block cipher in counter mode with a writable byte s-box
// sequence: a data beat taken from the input buffer passes two key schedule
//   reads, ROUND_COUNT round reads and a finish state that registers its result
// a new beat is taken only in the idle or finish state; beats do not overlap
// reset: s-box reads as zero, low counter zero, no clearing pass
// ----------------------------------------------------------------------------
module spn16_ctr_cipher_top #(
  parameter int unsigned ROUND_COUNT = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic                           in_start_message,
  input  logic [7:0]                     in_table_index,
  input  logic [7:0]                     in_table_value,
  input  logic [15:0]                    in_data_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_result_block,
  output logic [15:0]                    out_counter_used,
  output logic [15:0]                    out_keystream,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spn16_pkg::PADDR_W-1:0]  paddr,
  input  logic [spn16_pkg::PDATA_W-1:0]  pwdata,
  output logic [spn16_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  spn16_pkg::cfg_t      cfg;
  spn16_pkg::sbox_req_t sbox_req;
  spn16_pkg::item_t     pend_item_r, pend_item_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 take;
  logic                 accept;
  logic [7:0]           sbox_rd_a;
  logic [7:0]           sbox_rd_b;

  assign in_stall = pend_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pend_item_nxt  = pend_item_r;
    pend_valid_nxt = pend_valid_r && !take;
    if (accept) begin
      pend_valid_nxt              = 1'b1;
      pend_item_nxt.kind          = in_kind;
      pend_item_nxt.start_message = in_start_message;
      pend_item_nxt.table_index   = in_table_index;
      pend_item_nxt.table_value   = in_table_value;
      pend_item_nxt.data_block    = in_data_block;
    end
  end

  always_ff @(posedge clk) begin
    pend_item_r <= pend_item_nxt;
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
  end

  spn16_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spn16_sbox u_sbox (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sbox_req),
    .rd_a  (sbox_rd_a),
    .rd_b  (sbox_rd_b)
  );

  spn16_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .pend_valid       (pend_valid_r),
    .pend_item        (pend_item_r),
    .take             (take),
    .sbox_req         (sbox_req),
    .sbox_rd_a        (sbox_rd_a),
    .sbox_rd_b        (sbox_rd_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .out_counter_used (out_counter_used),
    .out_keystream    (out_keystream)
  );

endmodule

[hdl/spn16_chk.sv]
// ----------------------------------------------------------------------------
// spn16_chk
// port-level checks of the spn16 ctr cipher, bound to the top level
// ----------------------------------------------------------------------------
`include "spn16_ctr_cipher_top_assert.svh"

module spn16_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [15:0]                    out_result_block,
  input logic [15:0]                    out_counter_used,
  input logic [15:0]                    out_keystream,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [spn16_pkg::PADDR_W-1:0]  paddr,
  input logic [spn16_pkg::PDATA_W-1:0]  pwdata,
  input logic [spn16_pkg::PDATA_W-1:0]  prdata,
  input logic                           pready
);

  logic [47:0] out_bus;
  logic        key_sel;
  logic        key_wr;

  assign out_bus = {out_result_block, out_counter_used, out_keystream};
  assign key_sel = (paddr[3:2] == spn16_pkg::REG_KEY);
  assign key_wr  = psel && penable && pwrite && key_sel;

  `SPN16_ASSERT_RST(a_reset_no_beat, !out_valid)

  `SPN16_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus))

  `SPN16_ASSERT_IMP(a_pready_high, psel, pready)

  `SPN16_ASSERT_IMP(a_key_readback, $past(key_wr) && key_sel, prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind spn16_ctr_cipher_top spn16_chk u_chk (.*);

[dv/spn16_ctr_cipher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spn16_ctr_cipher_top_tb
// Self-checking bench for the 16-bit spn counter mode cipher. A short table
// of beats after reset comes first; results that follow from an all-zero
// s-box are typed in, the rest are predicted. Then six phases of random
// s-box writes and data beats run. Each phase writes a key, nonce and bit
// permutation setting and sets a pattern of sender gaps and receiver
// stalls. Every result beat is compared field by field with the oldest
// expected block.
// ----------------------------------------------------------------------------
module spn16_ctr_cipher_top_tb;
  import spn16_pkg::*;

  localparam int ROUNDS        = 3;
  localparam int SETTLE_CYCLES = 24;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int PHASE_ITEMS   = 250;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] result_block;
    logic [15:0] counter_used;
    logic [15:0] keystream;
  } cipher_result_t;

  typedef struct packed {
    item_t          beat;
    logic           typed;
    cipher_result_t want;
  } directed_row_t;

  localparam int DIR_ROWS = 18;
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'h0000, 16'h0000}},
    '{'{KIND_DATA,  1'b0, 8'hFF, 8'hFF, 16'h0000}, 1'b1, '{16'h0000, 16'h0001, 16'h0000}},
    '{'{KIND_DATA,  1'b1, 8'h00, 8'h00, 16'hA5C3}, 1'b1, '{16'hA5C3, 16'h0000, 16'h0000}},
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'h5A3C}, 1'b1, '{16'h5A3C, 16'h0001, 16'h0000}},
    '{'{KIND_TABLE, 1'b1, 8'h00, 8'hFF, 16'hFFFF}, 1'b0, '0},
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{KIND_TABLE, 1'b0, 8'hFF, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{KIND_TABLE, 1'b0, 8'hFF, 8'hFF, 16'h0000}, 1'b0, '0},
    '{'{KIND_TABLE, 1'b0, 8'h80, 8'h5A, 16'h0000}, 1'b0, '0},
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'hFFFF}, 1'b0, '0},
    '{'{KIND_DATA,  1'b1, 8'hFF, 8'hFF, 16'h0000}, 1'b0, '0},
    '{'{KIND_TABLE, 1'b1, 8'h01, 8'h01, 16'h1234}, 1'b0, '0},
    '{'{KIND_TABLE, 1'b0, 8'h7F, 8'h80, 16'h0000}, 1'b0, '0},
    '{'{KIND_TABLE, 1'b0, 8'h30, 8'hC3, 16'h0000}, 1'b0, '0},
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'h8001}, 1'b0, '0},
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'h7FFE}, 1'b0, '0},
    '{'{KIND_DATA,  1'b1, 8'h00, 8'h00, 16'hFFFF}, 1'b0, '0},
    '{'{KIND_DATA,  1'b0, 8'h00, 8'h00, 16'h0000}, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic                in_kind          = 1'b0;
  logic                in_start_message = 1'b0;
  logic [7:0]          in_table_index   = '0;
  logic [7:0]          in_table_value   = '0;
  logic [15:0]         in_data_block    = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [15:0]         out_result_block;
  logic [15:0]         out_counter_used;
  logic [15:0]         out_keystream;
  logic                psel             = 1'b0;
  logic                penable          = 1'b0;
  logic                pwrite           = 1'b0;
  logic [PADDR_W-1:0]  paddr            = '0;
  logic [PDATA_W-1:0]  pwdata           = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // cipher state as the bench sees it
  logic [7:0]  sbox_copy [256];
  logic [7:0]  low_ctr      = '0;
  logic [15:0] key_copy     = '0;
  logic [7:0]  ctr_hi_copy  = '0;
  logic [23:0] perm_copy    = PERM_RESET;

  cipher_result_t expected_blocks [$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  spn16_ctr_cipher_top #(
    .ROUND_COUNT(ROUNDS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_start_message (in_start_message),
    .in_table_index   (in_table_index),
    .in_table_value   (in_table_value),
    .in_data_block    (in_data_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .out_counter_used (out_counter_used),
    .out_keystream    (out_keystream),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int i = 0; i < 256; i++) sbox_copy[8'(i)] = '0;
  end

  function automatic logic [7:0] bit_shuffle(input logic [7:0] b);
    logic [7:0] r;
    logic [2:0] src;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      src          = perm_copy[3*i +: 3];
      r[3'(7 - i)] = b[3'd7 - src];
    end
    return r;
  endfunction

  function automatic logic [15:0] spn_keystream(input logic [15:0] ctr);
    logic [7:0]  w [6];
    logic [15:0] sk [3];
    logic [15:0] m;
    w[0] = key_copy[15:8];
    w[1] = key_copy[7:0];
    w[2] = w[0] ^ KS_RCON_1 ^ sbox_copy[{w[1][3:0], w[1][7:4]}];
    w[3] = w[2] ^ w[1];
    w[4] = w[2] ^ KS_RCON_2 ^ sbox_copy[{w[3][3:0], w[3][7:4]}];
    w[5] = w[4] ^ w[3];
    sk[0] = {w[0], w[1]};
    sk[1] = {w[2], w[3]};
    sk[2] = {w[4], w[5]};
    m = ctr;
    for (int r = 0; r < ROUNDS; r++) begin
      m = m ^ sk[2'(r % 3)];
      m = {bit_shuffle(sbox_copy[m[15:8]]), bit_shuffle(sbox_copy[m[7:0]])};
    end
    return m;
  endfunction

  task automatic predict_cipher(input item_t it, output bit produced,
                                output cipher_result_t res);
    logic [15:0] ctr;
    produced = 1'b0;
    res      = '0;
    if (it.kind == KIND_TABLE) begin
      sbox_copy[it.table_index] = it.table_value;
    end else begin
      if (it.start_message) low_ctr = '0;
      ctr              = {ctr_hi_copy, low_ctr};
      res.keystream    = spn_keystream(ctr);
      res.counter_used = ctr;
      res.result_block = it.data_block ^ res.keystream;
      low_ctr          = low_ctr + 8'd1;
      produced         = 1'b1;
    end
  endtask

  task automatic send_beat(input item_t it, input bit typed, input cipher_result_t want);
    bit             produced;
    cipher_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= it.kind;
    in_start_message <= it.start_message;
    in_table_index   <= it.table_index;
    in_table_value   <= it.table_value;
    in_data_block    <= it.data_block;
    do @(posedge clk); while (in_stall);
    predict_cipher(it, produced, predicted);
    if (produced) expected_blocks.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_blocks.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KEY:      key_copy    = value[15:0];
      REG_CTR_HIGH: ctr_hi_copy = value[7:0];
      REG_PERM:     perm_copy   = value[23:0];
      default:      ;
    endcase
  endtask

  task automatic run_phase(input logic [15:0] key, input logic [7:0] ctr_hi,
                           input logic [23:0] perm, input int send_pct,
                           input int stall_pct, input int start_pct,
                           input bit hold_mid);
    item_t it;
    wait_idle(1'b1);
    write_reg(REG_KEY, {16'h0, key});
    write_reg(REG_CTR_HIGH, {24'h0, ctr_hi});
    write_reg(REG_PERM, {8'h0, perm});
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (hold_mid && n == PHASE_ITEMS / 2) wait_idle(1'b0);
      it.kind          = ($urandom_range(99) < 60) ? KIND_DATA : KIND_TABLE;
      it.start_message = ($urandom_range(99) < start_pct);
      it.table_index   = 8'($urandom_range(255));
      it.table_value   = 8'($urandom_range(255));
      it.data_block    = 16'($urandom_range(65535));
      send_beat(it, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    cipher_result_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h %h %h", $time,
                 out_result_block, out_counter_used, out_keystream);
        mismatch_count++;
      end else begin
        want = expected_blocks.pop_front();
        check_field("result_block", want.result_block, out_result_block);
        check_field("counter_used", want.counter_used, out_counter_used);
        check_field("keystream", want.keystream, out_keystream);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config, s-box all zero until the first table beat
    for (int r = 0; r < DIR_ROWS; r++)
      send_beat(DIRECTED[5'(r)].beat, DIRECTED[5'(r)].typed, DIRECTED[5'(r)].want);

    run_phase(16'h0000, 8'h00, PERM_RESET, 0, 0, 0, 1'b0);
    run_phase(16'hFFFF, 8'hFF, 24'h000000, 63, 0, 0, 1'b0);
    wait_idle(1'b1);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    run_phase(16'($urandom_range(65535)), 8'($urandom_range(255)), 24'hFFFFFF,
              0, 63, 4, 1'b1);
    run_phase(16'($urandom_range(65535)), 8'($urandom_range(255)),
              24'($urandom_range(24'hFFFFFF)), 14, 14, 10, 1'b0);
    run_phase(16'h8001, 8'h7F, PERM_RESET, 0, 0, 2, 1'b0);
    run_phase(16'($urandom_range(65535)), 8'($urandom_range(255)),
              24'($urandom_range(24'hFFFFFF)), 14, 14, 3, 1'b0);

    wait_idle(1'b1);
    if (mismatch_count == 0 && expected_blocks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/spn16_pkg.sv
hdl/spn16_ram.sv
hdl/spn16_sbox.sv
hdl/spn16_regs.sv
hdl/spn16_core.sv
hdl/spn16_ctr_cipher_top.sv
hdl/spn16_chk.sv
dv/spn16_ctr_cipher_top_tb.sv
